>>> src/vafc_pkg.sv
// vertex attribute fetch/convert: shared types and constants
// no dependencies; used by the top level and the testbench
package vafc_pkg;

  // element format codes
  localparam logic [2:0] FMT_INT8    = 3'd0;
  localparam logic [2:0] FMT_UINT8   = 3'd1;
  localparam logic [2:0] FMT_INT16   = 3'd2;
  localparam logic [2:0] FMT_UINT16  = 3'd3;
  localparam logic [2:0] FMT_INT32   = 3'd4;
  localparam logic [2:0] FMT_UINT32  = 3'd5;
  localparam logic [2:0] FMT_FLOAT32 = 3'd6;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_START_OFFSET = 3'd0;
  localparam logic [2:0] REG_STRIDE       = 3'd1;
  localparam logic [2:0] REG_COMPONENTS   = 3'd2;
  localparam logic [2:0] REG_FORMAT       = 3'd3;
  localparam logic [2:0] REG_NORMALIZE    = 3'd4;
  localparam logic [2:0] REG_TOTAL        = 3'd5;

  localparam int unsigned CFG_ADDR_W = 5;

  // constant results
  localparam logic [31:0] FP_POS_ONE = 32'h3F80_0000;

  // how the final stage builds the value
  typedef enum logic [2:0] {
    K_ZERO,
    K_PASS,
    K_ONE,
    K_INT,
    K_NORM
  } kind_t;

endpackage

>>> src/vafc_in_if.sv
// vertex input channel: valid/ready plus vertex number and attribute bytes
// no dependencies
interface vafc_in_if #(
  parameter int unsigned VERTEX_INDEX_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic [VERTEX_INDEX_BITS-1:0] vertex_number;
  logic [63:0]                  raw_bytes_low;
  logic [63:0]                  raw_bytes_high;

  modport source (output valid, vertex_number, raw_bytes_low, raw_bytes_high, input ready);
  modport sink   (input valid, vertex_number, raw_bytes_low, raw_bytes_high, output ready);
endinterface

>>> src/vafc_out_if.sv
// component result channel: valid/ready plus converted value and location
// no dependencies
interface vafc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic [25:0] element_index;
  logic [31:0] source_address;
  logic        last_component;

  modport source (output valid, value_bits, element_index, source_address, last_component,
                  input ready);
  modport sink   (input valid, value_bits, element_index, source_address, last_component,
                  output ready);
endinterface

>>> src/vertex_attribute_fetch_convert_unit.sv
// vertex attribute fetch and float conversion, top level
// depends on vafc_pkg, vafc_in_if, vafc_out_if
//
// Usage:
//  in_ch carries one vertex per transfer: its number and sixteen attribute
//  bytes, little-endian. out_ch carries one converted component per transfer
//  (IEEE single value, element index, byte address, last flag), up to
//  MAX_COMPONENTS per vertex, in component order.
//  The APB-style cfg_ port holds the six registers at byte address 4*i;
//  write them only while the block is idle. cfg_pready is always high.
//  A vertex in the vertex register passes the issue, classify and round
//  stages before its first component shows on out_ch. Components leave at
//  one per cycle while out_ch does not stall; the component issue counter
//  steps through the 1 to MAX_COMPONENTS components of a vertex, and the next
//  vertex is accepted as its last component issues. A skipped vertex (first
//  element index at or past element_total) leaves and gives nothing.
//  Reset empties all stages and loads the register reset values.
//  When out_ch stalls, the stages fill up and hold; in_ch.ready drops once
//  the vertex register cannot drain.
module vertex_attribute_fetch_convert_unit #(
  parameter int unsigned MAX_COMPONENTS    = 4,
  parameter int unsigned VERTEX_INDEX_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  vafc_in_if.sink                               in_ch,
  vafc_out_if.source                            out_ch,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [vafc_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);
  import vafc_pkg::*;

  localparam int unsigned VB = VERTEX_INDEX_BITS;
  localparam int unsigned CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int unsigned FW = (VB + 3 > 26) ? VB + 3 : 26;
  localparam int unsigned PW = VB + 12;

  // configuration registers
  logic [31:0] start_offset_r;
  logic [11:0] stride_r;
  logic [2:0]  comps_r;
  logic [2:0]  format_r;
  logic        normalize_r;
  logic [24:0] total_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_offset_r <= '0;
      stride_r       <= 12'd16;
      comps_r        <= 3'd4;
      format_r       <= FMT_FLOAT32;
      normalize_r    <= 1'b0;
      total_r        <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_OFFSET: start_offset_r <= cfg_pwdata;
        REG_STRIDE:       stride_r       <= cfg_pwdata[11:0];
        REG_COMPONENTS:   comps_r        <= cfg_pwdata[2:0];
        REG_FORMAT:       format_r       <= cfg_pwdata[2:0];
        REG_NORMALIZE:    normalize_r    <= cfg_pwdata[0];
        REG_TOTAL:        total_r        <= cfg_pwdata[24:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_START_OFFSET: cfg_prdata = start_offset_r;
      REG_STRIDE:       cfg_prdata = {20'd0, stride_r};
      REG_COMPONENTS:   cfg_prdata = {29'd0, comps_r};
      REG_FORMAT:       cfg_prdata = {29'd0, format_r};
      REG_NORMALIZE:    cfg_prdata = {31'd0, normalize_r};
      REG_TOTAL:        cfg_prdata = {7'd0, total_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // pipeline handshake
  logic s1_v_r, s2_v_r, out_v_r;
  logic adv1, adv2, adv3;
  assign adv3 = !out_v_r || out_ch.ready;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;

  // vertex register
  logic          ir_v_r;
  logic [VB-1:0] vertex_r;
  logic [127:0]  bytes_r;
  logic [CW-1:0] c_r;
  logic          in_xfer;

  // issue stage signals
  logic [2:0]    comps_eff;
  logic [1:0]    size_log;
  logic [FW-1:0] first_idx;
  logic          skip;
  logic          issue;
  logic          issue_last;
  logic          ir_done;
  logic [3:0]    pos;
  logic [PW-1:0] stride_prod;
  logic [31:0]   base_addr;
  logic [127:0]  shifted;
  logic [31:0]   raw_sel;

  always_comb begin
    if (comps_r == 3'd0) begin
      comps_eff = 3'd1;
    end else if (comps_r > 3'(MAX_COMPONENTS)) begin
      comps_eff = 3'(MAX_COMPONENTS);
    end else begin
      comps_eff = comps_r;
    end
    case (format_r)
      FMT_INT8, FMT_UINT8:   size_log = 2'd0;
      FMT_INT16, FMT_UINT16: size_log = 2'd1;
      default:               size_log = 2'd2;
    endcase
  end

  assign first_idx   = FW'(vertex_r) * FW'(comps_eff);
  assign skip        = first_idx >= FW'(total_r);
  assign issue_last  = c_r == CW'(comps_eff - 3'd1);
  assign issue       = ir_v_r && !skip && adv1;
  assign ir_done     = ir_v_r && (skip || (issue && issue_last));
  assign in_ch.ready = !ir_v_r || ir_done;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign pos         = 4'(c_r) << size_log;
  assign stride_prod = PW'(vertex_r) * PW'(stride_r);
  assign base_addr   = start_offset_r + 32'(stride_prod);
  assign shifted     = bytes_r >> {pos, 3'd0};

  // byte gather masked to the element size
  always_comb begin
    case (size_log)
      2'd0:    raw_sel = {24'd0, shifted[7:0]};
      2'd1:    raw_sel = {16'd0, shifted[15:0]};
      default: raw_sel = shifted[31:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_v_r <= 1'b0;
      c_r    <= '0;
    end else if (in_xfer) begin
      ir_v_r <= 1'b1;
      c_r    <= '0;
    end else begin
      if (ir_done) begin
        ir_v_r <= 1'b0;
      end
      if (issue) begin
        c_r <= c_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      vertex_r <= in_ch.vertex_number;
      bytes_r  <= {in_ch.raw_bytes_high, in_ch.raw_bytes_low};
    end
  end

  // stage 1: one component's raw bits and location
  logic [31:0] s1_raw_r;
  logic [2:0]  s1_fmt_r;
  logic        s1_norm_r;
  logic [25:0] s1_idx_r;
  logic [31:0] s1_addr_r;
  logic        s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_raw_r  <= raw_sel;
      s1_fmt_r  <= format_r;
      s1_norm_r <= normalize_r;
      s1_idx_r  <= 26'(first_idx + FW'(c_r));
      s1_addr_r <= base_addr + 32'(pos);
      s1_last_r <= issue_last;
    end
  end

  // stage 2: sign, magnitude, leading zero count, result kind
  logic [31:0] sx;
  logic        sgn;
  logic [31:0] mag;
  logic [16:0] nrm_div;
  logic [5:0]  lz;
  kind_t       kind_nxt;
  logic        sgn_nxt;

  always_comb begin
    sx      = s1_raw_r;
    sgn     = 1'b0;
    nrm_div = 17'd0;
    case (s1_fmt_r)
      FMT_INT8: begin
        sx      = {{24{s1_raw_r[7]}}, s1_raw_r[7:0]};
        sgn     = s1_raw_r[7];
        nrm_div = 17'd127;
      end
      FMT_UINT8:  nrm_div = 17'd255;
      FMT_INT16: begin
        sx      = {{16{s1_raw_r[15]}}, s1_raw_r[15:0]};
        sgn     = s1_raw_r[15];
        nrm_div = 17'd32767;
      end
      FMT_UINT16: nrm_div = 17'd65535;
      FMT_INT32:  sgn     = s1_raw_r[31];
      default: ;
    endcase
    mag = sgn ? (~sx + 32'd1) : sx;
  end

  always_comb begin
    lz = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) begin
        lz = 6'(31 - i);
      end
    end
  end

  always_comb begin
    sgn_nxt = sgn;
    if (s1_fmt_r == FMT_FLOAT32) begin
      kind_nxt = K_PASS;
      sgn_nxt  = 1'b0;
    end else if (s1_fmt_r > FMT_FLOAT32 || mag == 32'd0) begin
      kind_nxt = K_ZERO;
      sgn_nxt  = 1'b0;
    end else if (s1_norm_r && nrm_div != 17'd0) begin
      // at or past the divisor: exactly one, or clamped at minus one
      kind_nxt = (mag >= 32'(nrm_div)) ? K_ONE : K_NORM;
    end else begin
      kind_nxt = K_INT;
    end
  end

  kind_t       s2_kind_r;
  logic        s2_sgn_r;
  logic [31:0] s2_mag_r;
  logic [4:0]  s2_lz_r;
  logic [2:0]  s2_fmt_r;
  logic [25:0] s2_idx_r;
  logic [31:0] s2_addr_r;
  logic        s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_kind_r <= kind_nxt;
      s2_sgn_r  <= sgn_nxt;
      s2_mag_r  <= mag;
      s2_lz_r   <= lz[4:0];
      s2_fmt_r  <= s1_fmt_r;
      s2_idx_r  <= s1_idx_r;
      s2_addr_r <= s1_addr_r;
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: normalize and round to nearest even
  logic [31:0] int_sh;
  logic [24:0] int_m;
  logic        int_up;
  logic [7:0]  int_exp;
  logic [4:0]  nbits;
  logic [47:0] rep;
  logic [4:0]  j0;
  logic [47:0] rep_sh;
  logic [24:0] nrm_m;
  logic [7:0]  nrm_exp;
  logic [31:0] value_nxt;

  always_comb begin
    int_sh  = s2_mag_r << s2_lz_r;
    int_up  = int_sh[7] && ((|int_sh[6:0]) || int_sh[8]);
    int_m   = {1'b0, int_sh[31:8]} + 25'(int_up);
    int_exp = 8'(9'd158 - 9'(s2_lz_r) + 9'(int_m[24]));
  end

  // v / (2^n - 1) is the n-bit pattern of v repeated without end;
  // the tail never terminates, so the round bit alone decides
  always_comb begin
    case (s2_fmt_r)
      FMT_INT8: begin
        nbits = 5'd7;
        rep   = {{6{s2_mag_r[6:0]}}, s2_mag_r[6:1]};
      end
      FMT_UINT8: begin
        nbits = 5'd8;
        rep   = {6{s2_mag_r[7:0]}};
      end
      FMT_INT16: begin
        nbits = 5'd15;
        rep   = {{3{s2_mag_r[14:0]}}, s2_mag_r[14:12]};
      end
      default: begin
        nbits = 5'd16;
        rep   = {3{s2_mag_r[15:0]}};
      end
    endcase
    j0      = 5'(6'(s2_lz_r) + 6'(nbits) - 6'd32);
    rep_sh  = rep << j0;
    nrm_m   = {1'b0, rep_sh[47:24]} + 25'(rep_sh[23]);
    nrm_exp = 8'(9'd158 - 9'(s2_lz_r) - 9'(nbits) + 9'(nrm_m[24]));
  end

  always_comb begin
    case (s2_kind_r)
      K_PASS:  value_nxt = s2_mag_r;
      K_ONE:   value_nxt = {s2_sgn_r, FP_POS_ONE[30:0]};
      K_INT:   value_nxt = {s2_sgn_r, int_exp,
                            int_m[24] ? int_m[23:1] : int_m[22:0]};
      K_NORM:  value_nxt = {s2_sgn_r, nrm_exp,
                            nrm_m[24] ? nrm_m[23:1] : nrm_m[22:0]};
      default: value_nxt = '0;
    endcase
  end

  logic [31:0] out_value_r;
  logic [25:0] out_idx_r;
  logic [31:0] out_addr_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv3) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      out_value_r <= value_nxt;
      out_idx_r   <= s2_idx_r;
      out_addr_r  <= s2_addr_r;
      out_last_r  <= s2_last_r;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.value_bits     = out_value_r;
  assign out_ch.element_index  = out_idx_r;
  assign out_ch.source_address = out_addr_r;
  assign out_ch.last_component = out_last_r;

  // component counter steps once per issued non-final component
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && !issue_last && !in_xfer) |=> (ir_v_r && c_r == $past(c_r) + 1'b1))
    else $error("component counter did not advance");

  // a new vertex always starts at component zero
  a_count_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (ir_v_r && c_r == '0))
    else $error("vertex started at nonzero component");

  // reset empties every stage
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!ir_v_r && !s1_v_r && !s2_v_r && !out_v_r))
    else $error("stage valid after reset");

endmodule

>>> test/testbench.sv
// testbench for vertex_attribute_fetch_convert_unit: directed table then random vertices
// depends on vafc_pkg, vafc_in_if, vafc_out_if and the top level in src
`timescale 1ns / 1ps

module testbench;
  import vafc_pkg::*;

  typedef struct {
    logic [31:0] offset;
    logic [11:0] stride;
    logic [2:0]  comps;
    logic [2:0]  fmt;
    logic        norm;
    logic [24:0] total;
  } attr_cfg_t;

  typedef struct {
    logic [31:0] value_bits;
    logic [25:0] element_index;
    logic [31:0] source_address;
    logic        last_component;
  } component_t;

  typedef struct {
    int          cfg_sel;
    logic [23:0] vertex;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        check_value;
    logic [31:0] value;
  } vertex_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  vafc_in_if  in_if ();
  vafc_out_if out_if ();

  vertex_attribute_fetch_convert_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  attr_cfg_t  cur_cfg;
  component_t pending_components[$];
  int         mismatches = 0;
  bit         steady = 0;
  bit         hold_req = 0;
  int         idle_cycles = 0;

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // unsigned 32 bit to single, round to nearest even
  function automatic logic [31:0] u32_to_float(logic [31:0] v);
    int unsigned p;
    int unsigned sh;
    logic [31:0] keep, rem, half;
    if (v == 0) return 32'h0;
    p = 31;
    while (v[p] == 1'b0) p--;
    if (p <= 23) begin
      keep = v << (23 - p);
    end else begin
      sh = p - 23;
      rem = v & ((32'h1 << sh) - 1);
      half = 32'h1 << (sh - 1);
      keep = v >> sh;
      if (rem > half || (rem == half && keep[0])) begin
        keep++;
        if (keep == 32'h0100_0000) begin
          keep = keep >> 1;
          p++;
        end
      end
    end
    return {1'b0, 8'(p + 127), keep[22:0]};
  endfunction

  function automatic logic [31:0] s32_to_float(logic [31:0] v);
    if (v[31]) return 32'h8000_0000 | u32_to_float(-v);
    return u32_to_float(v);
  endfunction

  // exact quotient m/d rounded to single, clamped at -1 when signed
  function automatic logic [31:0] unit_scale(bit neg, int unsigned m, int unsigned d);
    longint unsigned q, r, num;
    int s;
    if (m == 0) return 32'h0;
    if (neg && m > d) return 32'hBF80_0000;
    s = 0;
    while (((longint'(m) << s) / d) < 64'h80_0000) s++;
    num = longint'(m) << s;
    q = num / d;
    r = num % d;
    if (2 * r > d || (2 * r == d && q[0])) q++;
    if (q == 64'h100_0000) begin
      q = q >> 1;
      s--;
    end
    return {neg, 8'(127 + 23 - s), q[22:0]};
  endfunction

  // converted components of one vertex under the current registers
  function automatic void convert_vertex(logic [23:0] vertex, logic [63:0] lo, logic [63:0] hi,
                                         ref component_t res[$]);
    logic [127:0] bytes;
    int unsigned comps, size, pos;
    longint unsigned first;
    logic [31:0] base, raw, bits;
    component_t c;
    bytes = {hi, lo};
    res.delete();
    comps = cur_cfg.comps;
    if (comps == 0) comps = 1;
    if (comps > 4) comps = 4;
    size = (cur_cfg.fmt <= FMT_UINT8) ? 1 : (cur_cfg.fmt <= FMT_UINT16) ? 2 : 4;
    first = longint'(vertex) * comps;
    if (first >= cur_cfg.total) return;
    base = cur_cfg.offset + vertex * cur_cfg.stride;
    for (int i = 0; i < comps; i++) begin
      pos = i * size;
      raw = 0;
      for (int k = 0; k < size; k++) raw[k*8 +: 8] = bytes[(pos + k)*8 +: 8];
      case (cur_cfg.fmt)
        FMT_INT8:
          bits = cur_cfg.norm ? unit_scale(raw[7], raw[7] ? 256 - raw[7:0] : raw[7:0], 127)
                              : s32_to_float({{24{raw[7]}}, raw[7:0]});
        FMT_UINT8:
          bits = cur_cfg.norm ? unit_scale(0, raw[7:0], 255) : u32_to_float(raw);
        FMT_INT16:
          bits = cur_cfg.norm ? unit_scale(raw[15], raw[15] ? 65536 - raw[15:0] : raw[15:0],
                                           32767)
                              : s32_to_float({{16{raw[15]}}, raw[15:0]});
        FMT_UINT16:
          bits = cur_cfg.norm ? unit_scale(0, raw[15:0], 65535) : u32_to_float(raw);
        FMT_INT32:   bits = s32_to_float(raw);
        FMT_UINT32:  bits = u32_to_float(raw);
        FMT_FLOAT32: bits = raw;
        default:     bits = 32'h0;
      endcase
      c.value_bits     = bits;
      c.element_index  = 26'(first + i);
      c.source_address = base + pos;
      c.last_component = (i + 1 == comps);
      res.push_back(c);
    end
  endfunction

  // one APB write: setup then access; psel stays up for a following write
  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    cfg_psel    <= 1;
    cfg_penable <= 0;
    cfg_pwrite  <= 1;
    cfg_paddr   <= CFG_ADDR_W'(idx) << 2;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // stop offering and wait out the pipeline, skipped vertices included
  task automatic drain();
    in_if.valid <= 0;
    @(posedge clk);
    while (pending_components.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_cfg(attr_cfg_t c);
    drain();
    reg_write(REG_START_OFFSET, c.offset);
    reg_write(REG_STRIDE, 32'(c.stride));
    reg_write(REG_COMPONENTS, 32'(c.comps));
    reg_write(REG_FORMAT, 32'(c.fmt));
    reg_write(REG_NORMALIZE, 32'(c.norm));
    reg_write(REG_TOTAL, 32'(c.total));
    cfg_psel    <= 0;
    cfg_penable <= 0;
    cur_cfg = c;
  endtask

  // offer one vertex until it transfers, then record its components
  task automatic send_vertex(logic [23:0] vertex, logic [63:0] lo, logic [63:0] hi,
                             logic check_value, logic [31:0] value);
    component_t res[$];
    while (!steady && $urandom_range(99) < 7) begin
      in_if.valid <= 0;
      @(posedge clk);
    end
    in_if.valid          <= 1;
    in_if.vertex_number  <= vertex;
    in_if.raw_bytes_low  <= lo;
    in_if.raw_bytes_high <= hi;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    convert_vertex(vertex, lo, hi, res);
    if (check_value && res.size() > 0) res[0].value_bits = value;
    foreach (res[i]) pending_components.push_back(res[i]);
  endtask

  // result side: random stalls plus a requested long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        out_if.ready <= 0;
        hold_left--;
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= 7);
      end
    end
  end

  // compare each component transfer with the oldest expectation
  always @(posedge clk) begin
    component_t exp_c;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_components.size() == 0) begin
        $error("unexpected component transfer, index %0d", out_if.element_index);
        mismatches++;
      end else begin
        exp_c = pending_components.pop_front();
        if (out_if.value_bits !== exp_c.value_bits) begin
          $error("value_bits expected %h actual %h", exp_c.value_bits, out_if.value_bits);
          mismatches++;
        end
        if (out_if.element_index !== exp_c.element_index) begin
          $error("element_index expected %0d actual %0d", exp_c.element_index,
                 out_if.element_index);
          mismatches++;
        end
        if (out_if.source_address !== exp_c.source_address) begin
          $error("source_address expected %h actual %h", exp_c.source_address,
                 out_if.source_address);
          mismatches++;
        end
        if (out_if.last_component !== exp_c.last_component) begin
          $error("last_component expected %b actual %b", exp_c.last_component,
                 out_if.last_component);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    attr_cfg_t   dir_cfg[11];
    vertex_row_t dir_rows[$];
    attr_cfg_t   rc;
    rst_n = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    in_if.valid = 0; in_if.vertex_number = 0;
    in_if.raw_bytes_low = 0; in_if.raw_bytes_high = 0;
    cur_cfg = '{32'h0, 12'd16, 3'd4, FMT_FLOAT32, 1'b0, 25'd0};

    dir_cfg[0]  = '{32'h0, 12'd16, 3'd4, FMT_FLOAT32, 1'b0, 25'd0};
    dir_cfg[1]  = '{32'h0, 12'd16, 3'd4, FMT_FLOAT32, 1'b0, 25'h100_0000};
    dir_cfg[2]  = '{32'd100, 12'd4, 3'd4, FMT_INT8, 1'b1, 25'd1000};
    dir_cfg[3]  = '{32'h0, 12'd8, 3'd4, FMT_INT16, 1'b1, 25'd1000};
    dir_cfg[4]  = '{32'h0, 12'd4, 3'd4, FMT_UINT8, 1'b1, 25'd1000};
    dir_cfg[5]  = '{32'h0, 12'd8, 3'd4, FMT_UINT16, 1'b1, 25'd1000};
    dir_cfg[6]  = '{32'hFFFF_FFF0, 12'hFFF, 3'd4, FMT_INT32, 1'b1, 25'd1000};
    dir_cfg[7]  = '{32'h0, 12'd16, 3'd4, FMT_UINT32, 1'b0, 25'd8};
    dir_cfg[8]  = '{32'h0, 12'd16, 3'd0, FMT_INT8, 1'b0, 25'h100_0000};
    dir_cfg[9]  = '{32'h0, 12'd16, 3'd7, 3'd7, 1'b0, 25'h100_0000};
    dir_cfg[10] = '{32'hFFFF_FFFF, 12'd0, 3'd1, FMT_UINT16, 1'b0, 25'h100_0000};

    // after reset nothing is in range, so the first row gives no components
    dir_rows = '{
      '{0, 24'd0, 64'h0, 64'h0, 1'b0, 32'h0},
      '{1, 24'd0, 64'hBF80_0000_3F80_0000, 64'h7F80_0000_FFFF_FFFF, 1'b1, 32'h3F80_0000},
      '{2, 24'd1, 64'h0000_0000_017F_8180, 64'h0, 1'b1, 32'hBF80_0000},
      '{3, 24'd2, 64'h0000_0001_7FFF_8000, 64'h0, 1'b1, 32'hBF80_0000},
      '{4, 24'd3, 64'h0000_0000_0080_00FF, 64'h0, 1'b1, 32'h3F80_0000},
      '{5, 24'd0, 64'h0000_8000_0001_FFFF, 64'h0, 1'b1, 32'h3F80_0000},
      '{6, 24'd7, 64'h7FFF_FFFF_8000_0000, 64'h1, 1'b1, 32'hCF00_0000},
      '{7, 24'd1, 64'h0100_0001_FFFF_FFFF, 64'h0000_0003_0100_0003, 1'b1, 32'h4F80_0000},
      '{7, 24'd2, 64'h0100_0001_FFFF_FFFF, 64'h0, 1'b0, 32'h0},
      '{8, 24'd5, 64'h80, 64'h0, 1'b1, 32'hC300_0000},
      '{9, 24'd3, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0},
      '{10, 24'hFF_FFFF, 64'hFFFF, 64'h0, 1'b1, 32'h477F_FF00},
      '{1, 24'hFF_FFFF, 64'h0, 64'h0, 1'b0, 32'h0},
      '{1, 24'h3F_FFFF, 64'hFFFF_FFFF_0000_0001, 64'h8000_0000_0000_0000, 1'b0, 32'h0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_sel != 0 && (i == 0 || dir_rows[i].cfg_sel != dir_rows[i-1].cfg_sel))
        load_cfg(dir_cfg[dir_rows[i].cfg_sel]);
      send_vertex(dir_rows[i].vertex, dir_rows[i].lo, dir_rows[i].hi,
                  dir_rows[i].check_value, dir_rows[i].value);
    end

    // random vertices, new registers every 26 of them
    for (int n = 0; n < 260; n++) begin
      if (n % 26 == 0) begin
        rc.offset = $urandom();
        case ($urandom_range(2))
          0: rc.stride = 12'd0;
          1: rc.stride = 12'hFFF;
          default: rc.stride = 12'($urandom_range(0, 2048));
        endcase
        rc.comps = 3'($urandom_range(7));
        rc.fmt   = 3'($urandom_range(7));
        rc.norm  = 1'($urandom_range(1));
        rc.total = (n != 26 && $urandom_range(3) == 0) ? 25'($urandom_range(0, 200))
                                                       : 25'h100_0000;
        load_cfg(rc);
      end
      if (n == 40) hold_req = 1;
      if (n == 80) drain();
      steady = (n >= 150 && n < 200);
      send_vertex(($urandom_range(4) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 60)),
                  {$urandom(), $urandom()}, {$urandom(), $urandom()}, 1'b0, 32'h0);
    end
    steady = 0;
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
